// File: rtl/cmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmf_pkg
// Shared types for the cube map face and coordinate pipeline.
// ----------------------------------------------------------------------------
package cmf_pkg;

  // Cube face codes, chosen by major axis and its sign
  typedef enum logic [2:0] {
    FACE_RIGHT  = 3'd0,
    FACE_LEFT   = 3'd1,
    FACE_TOP    = 3'd2,
    FACE_BOTTOM = 3'd3,
    FACE_FRONT  = 3'd4,
    FACE_BACK   = 3'd5
  } face_e;

  // Side information that rides along with the coordinate math
  typedef struct packed {
    logic  hit;
    face_e face;
  } cmf_side_t;

endpackage : cmf_pkg
`default_nettype wire

// File: rtl/cmf_select.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmf_select
// Four-stage front end: takes magnitudes, picks the major axis and face,
// and forms the numerator and divisor of both face coordinates.
// ----------------------------------------------------------------------------
module cmf_select #(
  parameter int COMPONENT_BITS = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire  [COMPONENT_BITS-1:0]          dir_x_i,
  input  wire  [COMPONENT_BITS-1:0]          dir_y_i,
  input  wire  [COMPONENT_BITS-1:0]          dir_z_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output cmf_pkg::cmf_side_t                 out_side_o,
  output logic [COMPONENT_BITS:0]            num_u_o,
  output logic [COMPONENT_BITS:0]            num_v_o,
  output logic [COMPONENT_BITS:0]            den_o
);
  import cmf_pkg::*;

  localparam int CB = COMPONENT_BITS;

  // Two's complement magnitude; the most negative value maps to 2^(CB-1)
  function automatic logic [CB-1:0] mag_of(input logic [CB-1:0] v);
    return v[CB-1] ? (~v + 1'b1) : v;
  endfunction

  // Stage registers
  logic                 v1_q, v2_q, v3_q, v4_q;
  logic                 r1, r2, r3, r4;
  logic [CB-1:0]        x1_q, y1_q, z1_q;
  logic [CB-1:0]        x2_q, y2_q, z2_q;
  logic [CB-1:0]        ax2_q, ay2_q, az2_q;
  logic [CB-1:0]        m3_q, m3_d;
  logic [CB-1:0]        au3_q, au3_d, av3_q, av3_d;
  logic                 subu3_q, subu3_d, subv3_q, subv3_d;
  cmf_side_t            side3_q, side3_d;
  logic [CB:0]          nu4_q, nu4_d, nv4_q, nv4_d, d4_q, d4_d;
  cmf_side_t            side4_q;

  // Per-stage ready: a stage loads when empty or when its successor moves
  assign r4         = !v4_q || out_ready_i;
  assign r3         = !v3_q || r4;
  assign r2         = !v2_q || r3;
  assign r1         = !v1_q || r2;
  assign in_ready_o = r1;

  // Pick the major axis; ties go to x, then y, then z
  logic xmaj, ymaj, neg;
  always_comb begin
    xmaj    = (ax2_q >= ay2_q) && (ax2_q >= az2_q);
    ymaj    = !xmaj && (ay2_q >= az2_q);
    neg     = 1'b0;
    m3_d    = az2_q;
    au3_d   = x2_q;
    av3_d   = y2_q;
    subu3_d = 1'b0;
    subv3_d = 1'b0;
    side3_d = '{hit: 1'b0, face: FACE_RIGHT};
    if (xmaj) begin
      neg          = x2_q[CB-1];
      m3_d         = ax2_q;
      au3_d        = z2_q;
      av3_d        = y2_q;
      subu3_d      = !neg;
      subv3_d      = 1'b0;
      side3_d.face = neg ? FACE_LEFT : FACE_RIGHT;
    end else if (ymaj) begin
      neg          = y2_q[CB-1];
      m3_d         = ay2_q;
      au3_d        = x2_q;
      av3_d        = z2_q;
      subu3_d      = 1'b0;
      subv3_d      = 1'b1;
      side3_d.face = neg ? FACE_BOTTOM : FACE_TOP;
    end else begin
      neg          = z2_q[CB-1];
      m3_d         = az2_q;
      au3_d        = x2_q;
      av3_d        = y2_q;
      subu3_d      = neg;
      subv3_d      = 1'b0;
      side3_d.face = neg ? FACE_BACK : FACE_FRONT;
    end
    side3_d.hit = (m3_d != '0);
  end

  // Numerators m +/- minor (sign of the major folded into the subtract flag)
  logic signed [CB+1:0] m_ext, au_ext, av_ext, nu_sum, nv_sum;
  always_comb begin
    m_ext  = $signed({2'b00, m3_q});
    au_ext = $signed({{2{au3_q[CB-1]}}, au3_q});
    av_ext = $signed({{2{av3_q[CB-1]}}, av3_q});
    nu_sum = subu3_q ? (m_ext - au_ext) : (m_ext + au_ext);
    nv_sum = subv3_q ? (m_ext - av_ext) : (m_ext + av_ext);
    nu4_d  = nu_sum[CB:0];
    nv4_d  = nv_sum[CB:0];
    d4_d   = {m3_q, 1'b0};
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (r1) begin
      x1_q <= dir_x_i;
      y1_q <= dir_y_i;
      z1_q <= dir_z_i;
    end
    if (r2) begin
      x2_q  <= x1_q;
      y2_q  <= y1_q;
      z2_q  <= z1_q;
      ax2_q <= mag_of(x1_q);
      ay2_q <= mag_of(y1_q);
      az2_q <= mag_of(z1_q);
    end
    if (r3) begin
      m3_q    <= m3_d;
      au3_q   <= au3_d;
      av3_q   <= av3_d;
      subu3_q <= subu3_d;
      subv3_q <= subv3_d;
      side3_q <= side3_d;
    end
    if (r4) begin
      nu4_q   <= nu4_d;
      nv4_q   <= nv4_d;
      d4_q    <= d4_d;
      side4_q <= side3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign out_side_o  = side4_q;
  assign num_u_o     = nu4_q;
  assign num_v_o     = nv4_q;
  assign den_o       = d4_q;

endmodule : cmf_select
`default_nettype wire

// File: rtl/cmf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmf_div
// Pipelined restoring divider for both face coordinates: one quotient bit
// per stage, floor(num * 2^COORD_BITS / den) with num <= den.
// ----------------------------------------------------------------------------
module cmf_div #(
  parameter int COMPONENT_BITS = 16,
  parameter int COORD_BITS     = 16
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  cmf_pkg::cmf_side_t        in_side_i,
  input  wire  [COMPONENT_BITS:0]   num_u_i,
  input  wire  [COMPONENT_BITS:0]   num_v_i,
  input  wire  [COMPONENT_BITS:0]   den_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output cmf_pkg::cmf_side_t        out_side_o,
  output logic [COORD_BITS:0]       quo_u_o,
  output logic [COORD_BITS:0]       quo_v_o
);
  import cmf_pkg::*;

  localparam int STEPS = COORD_BITS + 1;
  localparam int RW    = COMPONENT_BITS + 1;
  localparam int QW    = COORD_BITS + 1;

  // Subtract if it fits, then shift the partial remainder up
  function automatic logic [RW-1:0] rem_step(input logic [RW-1:0] r, input logic [RW-1:0] d);
    logic [RW-1:0] rs;
    rs = (r >= d) ? (r - d) : r;
    return {rs[RW-2:0], 1'b0};
  endfunction

  logic [STEPS-1:0] v_q;
  logic [STEPS-1:0] v_in;
  logic [STEPS:0]   rdy;
  logic [RW-1:0]    ru_q [STEPS];
  logic [RW-1:0]    rv_q [STEPS];
  logic [RW-1:0]    d_q  [STEPS];
  logic [QW-1:0]    qu_q [STEPS];
  logic [QW-1:0]    qv_q [STEPS];
  cmf_side_t        side_q [STEPS];
  logic [RW-1:0]    ru_n [STEPS];
  logic [RW-1:0]    rv_n [STEPS];
  logic [QW-1:0]    qu_n [STEPS];
  logic [QW-1:0]    qv_n [STEPS];

  // Ready ripples back from the output
  always_comb begin
    rdy[STEPS] = out_ready_i;
    for (int k = STEPS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end
  assign in_ready_o = rdy[0];
  assign v_in       = {v_q[STEPS-2:0], in_valid_i};

  // One quotient bit per stage, both lanes
  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      qu_n[k] = {qu_q[k][QW-2:0], (ru_q[k] >= d_q[k])};
      qv_n[k] = {qv_q[k][QW-2:0], (rv_q[k] >= d_q[k])};
      ru_n[k] = rem_step(ru_q[k], d_q[k]);
      rv_n[k] = rem_step(rv_q[k], d_q[k]);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < STEPS; k++) begin
        if (rdy[k]) v_q[k] <= v_in[k];
      end
    end
  end

  // Advance remainders, quotients and side data
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      ru_q[0]   <= num_u_i;
      rv_q[0]   <= num_v_i;
      d_q[0]    <= den_i;
      qu_q[0]   <= '0;
      qv_q[0]   <= '0;
      side_q[0] <= in_side_i;
    end
    for (int k = 1; k < STEPS; k++) begin
      if (rdy[k]) begin
        ru_q[k]   <= ru_n[k-1];
        rv_q[k]   <= rv_n[k-1];
        d_q[k]    <= d_q[k-1];
        qu_q[k]   <= qu_n[k-1];
        qv_q[k]   <= qv_n[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // The last stage's bit is resolved combinationally into the output
  assign out_valid_o = v_q[STEPS-1];
  assign out_side_o  = side_q[STEPS-1];
  assign quo_u_o     = qu_n[STEPS-1];
  assign quo_v_o     = qv_n[STEPS-1];

endmodule : cmf_div
`default_nettype wire

// File: rtl/cube_map_face_and_uv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cube_map_face_and_uv
// Cube map face selection with exact fixed-point face coordinates.
// ----------------------------------------------------------------------------
// Takes one direction word (x, y, z) per cycle and returns the cube face of
// the largest-magnitude axis (ties to x, then y, then z) together with u and
// v as unsigned COORD_BITS-bit fractions, 1.0 saturating to all ones; a zero
// vector returns hit = 0 with face, u and v cleared. Throughput is one word
// per cycle while the output keeps taking words. A four-stage select front
// end feeds the restoring divider, which resolves one quotient bit per stage
// (COORD_BITS + 1 stages), and one output register follows. Every stage holds
// its word under back-pressure and empty stages keep filling, so input is
// taken while a finished word waits at the output.
// ----------------------------------------------------------------------------
module cube_map_face_and_uv #(
  parameter int COMPONENT_BITS = 16,
  parameter int COORD_BITS     = 16
) (
  input  wire                                         clk_i,
  input  wire                                         rst_ni,
  input  wire                                         s_axis_tvalid,
  output logic                                        s_axis_tready,
  // dir_x, dir_y, dir_z (each COMPONENT_BITS, signed), zero padded
  input  wire  [((3*COMPONENT_BITS+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                        m_axis_tvalid,
  input  wire                                         m_axis_tready,
  // face (3), tex_u (COORD_BITS), tex_v (COORD_BITS), zero padded
  output logic [((3+2*COORD_BITS+7)/8)*8-1:0]         m_axis_tdata,
  // hit (1)
  output logic                                        m_axis_tuser
);
  import cmf_pkg::*;

  localparam int CB    = COMPONENT_BITS;
  localparam int CW    = COORD_BITS;
  localparam int OUT_W = ((3 + 2*COORD_BITS + 7) / 8) * 8;

  logic            sel_valid, sel_ready;
  cmf_side_t       sel_side;
  logic [CB:0]     num_u, num_v, den;
  logic            div_valid, div_ready;
  cmf_side_t       div_side;
  logic [CW:0]     quo_u, quo_v;

  cmf_select #(
    .COMPONENT_BITS(COMPONENT_BITS)
  ) u_select (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .dir_x_i     (s_axis_tdata[CB-1:0]),
    .dir_y_i     (s_axis_tdata[2*CB-1:CB]),
    .dir_z_i     (s_axis_tdata[3*CB-1:2*CB]),
    .out_valid_o (sel_valid),
    .out_ready_i (sel_ready),
    .out_side_o  (sel_side),
    .num_u_o     (num_u),
    .num_v_o     (num_v),
    .den_o       (den)
  );

  cmf_div #(
    .COMPONENT_BITS(COMPONENT_BITS),
    .COORD_BITS    (COORD_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sel_valid),
    .in_ready_o  (sel_ready),
    .in_side_i   (sel_side),
    .num_u_i     (num_u),
    .num_v_i     (num_v),
    .den_i       (den),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_side_o  (div_side),
    .quo_u_o     (quo_u),
    .quo_v_o     (quo_v)
  );

  // Output register: saturate 1.0, clear everything on a miss
  logic          out_v_q;
  logic          hit_q, hit_d;
  logic [2:0]    face_q, face_d;
  logic [CW-1:0] u_q, u_d, v_q, v_d;

  assign div_ready = !out_v_q || m_axis_tready;

  always_comb begin
    hit_d  = div_side.hit;
    face_d = div_side.face;
    u_d    = quo_u[CW] ? '1 : quo_u[CW-1:0];
    v_d    = quo_v[CW] ? '1 : quo_v[CW-1:0];
    if (!div_side.hit) begin
      face_d = FACE_RIGHT;
      u_d    = '0;
      v_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (div_ready) begin
      out_v_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_ready) begin
      hit_q  <= hit_d;
      face_q <= face_d;
      u_q    <= u_d;
      v_q    <= v_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = hit_q;
  assign m_axis_tdata  = OUT_W'({v_q, u_q, face_q});

endmodule : cube_map_face_and_uv
`default_nettype wire

// File: tb/cube_map_face_and_uv_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_map_face_and_uv_chk
// Scoreboard for the cube map face and coordinate pipeline.
// ----------------------------------------------------------------------------
// Watches both stream channels. Every direction word taken at the input is
// turned into the expected hit, face, u and v by an exact integer model of
// the face pick and the (r + 1) / 2 mapping, and queued. Every result word
// taken at the output is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module cube_map_face_and_uv_chk
  import cmf_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  input  wire         s_axis_tready_i,
  // dir_x [15:0], dir_y [31:16], dir_z [47:32]
  input  wire  [47:0] s_axis_tdata_i,
  input  wire         m_axis_tvalid_i,
  input  wire         m_axis_tready_i,
  // face [2:0], tex_u [18:3], tex_v [34:19], zero pad [39:35]
  input  wire  [39:0] m_axis_tdata_i,
  // hit
  input  wire         m_axis_tuser_i,
  output int          err_cnt_o,
  output int          pending_o
);

  localparam int CompBits  = 16;
  localparam int CoordBits = 16;
  localparam longint CoordMax = (longint'(1) << CoordBits) - 1;

  typedef struct {
    logic                 hit;
    face_e                face;
    logic [CoordBits-1:0] tex_u;
    logic [CoordBits-1:0] tex_v;
  } face_uv_t;

  face_uv_t face_uv_q[$];
  face_uv_t want;
  face_e    got_face;
  int       n_err = 0;

  // Direct (m + a) / 2m or mirrored (m - a) / 2m, truncated, 1.0 saturated
  function automatic logic [CoordBits-1:0] face_frac(longint a, longint m, bit mirror);
    longint n;
    longint q;
    n = mirror ? m - a : m + a;
    if (n < 0) n = 0;
    q = (n << (CoordBits - 1)) / m;
    if (q > CoordMax) q = CoordMax;
    return CoordBits'(q);
  endfunction

  // Pick the major axis (ties to x, then y, then z) and map the minors
  function automatic face_uv_t predict_face_uv(logic [47:0] word);
    longint   c[3];
    longint   mg[3];
    longint   s1;
    longint   s2;
    int       ax;
    bit       neg;
    bit       mu;
    bit       mv;
    face_uv_t r;
    for (int i = 0; i < 3; i++) begin
      c[i]  = longint'($signed(word[CompBits*i +: CompBits]));
      mg[i] = (c[i] < 0) ? -c[i] : c[i];
    end
    if (mg[0] >= mg[1] && mg[0] >= mg[2]) ax = 0;
    else if (mg[1] >= mg[0] && mg[1] >= mg[2]) ax = 1;
    else ax = 2;
    neg = c[ax] < 0;
    case (ax)
      0: begin
        r.face = neg ? FACE_LEFT : FACE_RIGHT;
        s1 = c[2];
        s2 = c[1];
        mu = 1'b1;
        mv = neg;
      end
      1: begin
        r.face = neg ? FACE_BOTTOM : FACE_TOP;
        s1 = c[0];
        s2 = c[2];
        mu = neg;
        mv = !neg;
      end
      default: begin
        r.face = neg ? FACE_BACK : FACE_FRONT;
        s1 = c[0];
        s2 = c[1];
        mu = 1'b0;
        mv = neg;
      end
    endcase
    // Zero vector: everything cleared
    if (c[ax] == 0) begin
      r.hit   = 1'b0;
      r.face  = FACE_RIGHT;
      r.tex_u = '0;
      r.tex_v = '0;
      return r;
    end
    if (neg) begin
      s1 = -s1;
      s2 = -s2;
    end
    r.hit   = 1'b1;
    r.tex_u = face_frac(s1, mg[ax], mu);
    r.tex_v = face_frac(s2, mg[ax], mv);
    return r;
  endfunction

  // Retire output words first, then queue the word taken at the input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (face_uv_q.size() == 0) begin
          $error("result word with nothing expected: tdata %h tuser %b",
                 m_axis_tdata_i, m_axis_tuser_i);
          n_err++;
        end else begin
          want     = face_uv_q.pop_front();
          got_face = face_e'(m_axis_tdata_i[2:0]);
          if (m_axis_tuser_i !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, m_axis_tuser_i);
            n_err++;
          end
          if (got_face !== want.face) begin
            $error("face: expected %0d, actual %0d", want.face, m_axis_tdata_i[2:0]);
            n_err++;
          end
          if (m_axis_tdata_i[18:3] !== want.tex_u) begin
            $error("tex_u: expected %0d, actual %0d", want.tex_u, m_axis_tdata_i[18:3]);
            n_err++;
          end
          if (m_axis_tdata_i[34:19] !== want.tex_v) begin
            $error("tex_v: expected %0d, actual %0d", want.tex_v, m_axis_tdata_i[34:19]);
            n_err++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        face_uv_q.push_back(predict_face_uv(s_axis_tdata_i));
      end
    end
    err_cnt_o <= n_err;
    pending_o <= face_uv_q.size();
  end

endmodule : cube_map_face_and_uv_chk

// File: tb/cube_map_face_and_uv_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_map_face_and_uv_tb
// Stream test of the cube map face and coordinate pipeline.
// ----------------------------------------------------------------------------
// Sends a short directed set of directions (zero vector, every face, ties,
// full-scale and most negative components, minors equal to the major) and
// then random directions weighted toward ties, small values and saturation.
// Both sides stall at random, the output is held off for a long stretch once
// so the pipeline backs up, and the checker scores every result word.
// ----------------------------------------------------------------------------
module cube_map_face_and_uv_tb;

  localparam int NumRandom  = 1650;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 40;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // dir_x [15:0], dir_y [31:16], dir_z [47:32]
  logic [47:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // face [2:0], tex_u [18:3], tex_v [34:19], zero pad [39:35]
  logic [39:0] m_tdata;
  // hit
  logic        m_tuser;
  int          err_cnt;
  int          pending;
  int          cycles   = 0;
  bit          steady_send = 1'b0;

  cube_map_face_and_uv dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  cube_map_face_and_uv_chk u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .err_cnt_o       (err_cnt),
    .pending_o       (pending)
  );

  always #5 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("cube_map_face_and_uv_tb NOT OK");
      $finish;
    end
  end

  // Output side: one long hold-off, one stretch always ready, random stalls
  initial begin
    int rx_cyc;
    rx_cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_cyc >= 300 && rx_cyc < 600) begin
        m_tready <= 1'b0;
      end else if (rx_cyc >= 1200 && rx_cyc < 1700) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 7);
      end
      rx_cyc++;
    end
  end

  // Offer one direction word, maybe after random idle cycles; returns at a
  // falling edge once the word is taken
  task automatic send_dir(input logic [15:0] x, input logic [15:0] y,
                          input logic [15:0] z);
    while (!steady_send && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    logic signed [15:0] dir_tab [25][3] = '{
      '{16'sd0, 16'sd0, 16'sd0},              // zero vector
      '{16'sd100, 16'sd0, 16'sd0},
      '{-16'sd100, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd100, 16'sd0},
      '{16'sd0, -16'sd100, 16'sd0},
      '{16'sd0, 16'sd0, 16'sd100},
      '{16'sd0, 16'sd0, -16'sd100},
      '{16'sd32767, 16'sd32767, 16'sd32767},  // three-way tie, u at 0 and v at 1.0
      '{-16'sd32768, -16'sd32768, -16'sd32768},
      '{-16'sd32768, 16'sd32767, -16'sd32767},
      '{16'sd5, -16'sd5, 16'sd3},
      '{16'sd1, 16'sd7, -16'sd7},
      '{16'sd0, -16'sd9, 16'sd9},
      '{16'sd32767, -16'sd32767, 16'sd32767},
      '{-16'sd32768, 16'sd0, 16'sd0},
      '{16'sd0, -16'sd32768, 16'sd32767},
      '{16'sd0, 16'sd0, -16'sd32768},
      '{16'sd1, 16'sd0, 16'sd0},
      '{-16'sd1, 16'sd1, -16'sd1},
      '{16'sd3, -16'sd2, 16'sd1},
      '{16'sd12345, -16'sd12345, -16'sd1},
      '{16'sd7, -16'sd7, 16'sd0},
      '{-16'sd32768, 16'sd32767, 16'sd0},
      '{16'sd0, 16'sd1, 16'sd0},
      '{-16'sd3, 16'sd0, -16'sd3}
    };
    logic signed [15:0] d [3];
    int kind;
    int mj;
    int rot;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed corners
    foreach (dir_tab[i]) send_dir(dir_tab[i][0], dir_tab[i][1], dir_tab[i][2]);

    // Random directions
    for (int n = 0; n < NumRandom; n++) begin
      steady_send = (n >= 700 && n < 1100);
      kind = $urandom_range(0, 9);
      rot  = $urandom_range(0, 2);
      case (kind)
        4, 5: begin
          // small values: many ties and zero vectors
          for (int i = 0; i < 3; i++) d[i] = 16'($urandom_range(0, 8) - 4);
        end
        6: begin
          // one full-scale axis
          for (int i = 0; i < 3; i++) d[i] = 16'($urandom);
          case ($urandom_range(0, 2))
            0:       d[0] = -16'sd32768;
            1:       d[0] = 16'sd32767;
            default: d[0] = -16'sd32767;
          endcase
        end
        7: begin
          // two axes tied in magnitude, the third no larger
          mj   = $urandom_range(0, 32767);
          d[0] = 16'($urandom_range(0, 1) ? mj : -mj);
          d[1] = 16'($urandom_range(0, 1) ? mj : -mj);
          d[2] = 16'(int'($urandom_range(0, 2 * mj)) - mj);
        end
        8: begin
          // minors at plus or minus the major or zero: coordinates at 0 and 1.0
          mj = $urandom_range(1, 32767);
          d[0] = 16'($urandom_range(0, 1) ? mj : -mj);
          for (int i = 1; i < 3; i++) begin
            case ($urandom_range(0, 2))
              0:       d[i] = 16'(mj);
              1:       d[i] = 16'(-mj);
              default: d[i] = '0;
            endcase
          end
        end
        9: begin
          // mixed magnitudes
          for (int i = 0; i < 3; i++) begin
            d[i] = $signed(16'($urandom)) >>> $urandom_range(0, 15);
          end
        end
        default: begin
          for (int i = 0; i < 3; i++) d[i] = 16'($urandom);
        end
      endcase
      send_dir(d[rot], d[(rot + 1) % 3], d[(rot + 2) % 3]);
    end
    steady_send = 1'b0;
    s_tvalid <= 1'b0;

    // Drain, then give stray words time to show up
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("cube_map_face_and_uv_tb OK");
    end else begin
      $display("cube_map_face_and_uv_tb NOT OK");
    end
    $finish;
  end

endmodule : cube_map_face_and_uv_tb
